>>> sv/bgat_pkg.sv
// Shared types and constants for the battery gauge converter tracker.
// Holds the input/result word structs and the low-segment map table.
// No dependencies.
package bgat_pkg;

  typedef struct packed {
    logic [9:0] adc_sample;
    logic       charger_present;
  } bgat_in_t;

  typedef struct packed {
    logic [6:0] percent;
    logic       charging;
    logic [2:0] level;
  } bgat_out_t;

  // Segment breakpoints on the converter sample
  localparam logic [9:0] SEG_HIGH_MIN = 10'd528;
  localparam logic [9:0] SEG_MID_MIN  = 10'd512;
  localparam logic [9:0] SEG_LOW_MIN  = 10'd480;
  localparam logic [9:0] SEG_HIGH_OFS = 10'd478;
  // 17*512 - 8544
  localparam logic [8:0] SEG_MID_OFS  = 9'd160;

  localparam logic [6:0] PCT_MAX = 7'd100;
  localparam logic [6:0] BAND_1  = 7'd20;
  localparam logic [6:0] BAND_2  = 7'd40;
  localparam logic [6:0] BAND_3  = 7'd60;
  localparam logic [6:0] BAND_4  = 7'd80;

  localparam logic [2:0] LEVEL_1        = 3'd1;
  localparam logic [2:0] LEVEL_2        = 3'd2;
  localparam logic [2:0] LEVEL_3        = 3'd3;
  localparam logic [2:0] LEVEL_4        = 3'd4;
  localparam logic [2:0] LEVEL_5        = 3'd5;
  localparam logic [2:0] LEVEL_CHARGING = 3'd6;

  // floor(0.51613*s - 243.742) for s = 480 + index, index 0..31
  localparam logic [4:0] SEG_LOW_LUT [32] = '{
    5'd4,  5'd4,  5'd5,  5'd5,  5'd6,  5'd6,  5'd7,  5'd7,
    5'd8,  5'd8,  5'd9,  5'd9,  5'd10, 5'd10, 5'd11, 5'd11,
    5'd12, 5'd12, 5'd13, 5'd13, 5'd14, 5'd14, 5'd15, 5'd15,
    5'd16, 5'd16, 5'd17, 5'd17, 5'd18, 5'd18, 5'd19, 5'd20
  };

endpackage

>>> sv/battery_gauge_adc_tracker_core.sv
// Battery gauge tracker: maps converter samples to a tracked percentage.
// Depends on bgat_pkg for the word structs, breakpoints and table.
//
// Usage:
//   in_valid/in_ready/in_data carry one word per sample: the 10-bit
//   converter reading and the charger-present flag. out_valid/out_ready/
//   out_data return exactly one result word per input word: percent, the
//   charging flag and the 1..6 level.
//   One input register, then the map, slew and band logic feeding the
//   result register, which drives out_valid.
//   Throughput is one word per cycle while the receiver is not stalling;
//   the limit is the update of the estimate register, which the next word
//   reads.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_ready drops only once both are full, and rises
//   again in the same cycle that out_ready frees the result register.
//   Reset (rst_n low, synchronous) empties both registers, clears the
//   estimate and the previous-charging flag, and arms the first
//   non-charging sample to snap the estimate to the mapped value.
module battery_gauge_adc_tracker_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bgat_pkg::bgat_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bgat_pkg::bgat_out_t out_data
);
  import bgat_pkg::*;

  logic       s1_v_r;
  bgat_in_t   s1_r;
  logic       out_v_r;
  bgat_out_t  out_r;
  logic [6:0] est_r;
  logic       need_cal_r;
  logic       prev_chg_r;

  logic       adv2;
  logic [9:0] samp;
  logic [3:0] mid_t;
  logic [8:0] mid_sum;
  logic [9:0] raw;
  logic [6:0] raw_pct;
  logic [6:0] est_nxt;
  logic [2:0] level;
  bgat_out_t  res_nxt;

  assign adv2      = s1_v_r && (!out_v_r || out_ready);
  assign in_ready  = !s1_v_r || adv2;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Three-segment map of the sample
  assign samp    = s1_r.adc_sample;
  assign mid_t   = samp[3:0];
  assign mid_sum = {1'b0, mid_t, 4'b0000} + {5'b00000, mid_t} + SEG_MID_OFS;

  always_comb begin
    if (samp >= SEG_HIGH_MIN) begin
      raw = samp - SEG_HIGH_OFS;
    end else if (samp >= SEG_MID_MIN) begin
      raw = {4'b0000, mid_sum[8:3]};
    end else if (samp >= SEG_LOW_MIN) begin
      raw = {5'b00000, SEG_LOW_LUT[samp[4:0]]};
    end else begin
      raw = '0;
    end
  end

  assign raw_pct = (raw > {3'b000, PCT_MAX}) ? PCT_MAX : raw[6:0];

  // Snap after reset or after charging, else slew one step toward the map or hold
  always_comb begin
    if (need_cal_r || prev_chg_r) begin
      est_nxt = raw_pct;
    end else if ({3'b000, est_r} > raw) begin
      est_nxt = est_r - 7'd1;
    end else if ({3'b000, est_r} < raw) begin
      est_nxt = (est_r >= PCT_MAX) ? PCT_MAX : est_r + 7'd1;
    end else begin
      est_nxt = est_r;
    end
  end

  always_comb begin
    if (est_nxt <= BAND_1) begin
      level = LEVEL_1;
    end else if (est_nxt <= BAND_2) begin
      level = LEVEL_2;
    end else if (est_nxt <= BAND_3) begin
      level = LEVEL_3;
    end else if (est_nxt <= BAND_4) begin
      level = LEVEL_4;
    end else begin
      level = LEVEL_5;
    end
  end

  always_comb begin
    if (s1_r.charger_present) begin
      res_nxt.percent  = '0;
      res_nxt.charging = 1'b1;
      res_nxt.level    = LEVEL_CHARGING;
    end else begin
      res_nxt.percent  = est_nxt;
      res_nxt.charging = 1'b0;
      res_nxt.level    = level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      est_r      <= '0;
      need_cal_r <= 1'b1;
      prev_chg_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (adv2) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (adv2) begin
        prev_chg_r <= s1_r.charger_present;
        if (!s1_r.charger_present) begin
          est_r      <= est_nxt;
          need_cal_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_r <= in_data;
    end
    if (adv2) begin
      out_r <= res_nxt;
    end
  end

  // Estimate stays in range
  a_est_range: assert property (@(posedge clk) disable iff (!rst_n)
    est_r <= PCT_MAX)
    else $error("estimate above full scale");

  // A slewing word moves the estimate by at most one
  a_slew_step: assert property (@(posedge clk) disable iff (!rst_n)
    (adv2 && !s1_r.charger_present && !need_cal_r && !prev_chg_r) |=>
      (est_r == $past(est_r) || est_r == $past(est_r) + 7'd1 ||
       est_r + 7'd1 == $past(est_r)))
    else $error("estimate slewed by more than one");

  // A charging word never touches the estimate
  a_chg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (adv2 && s1_r.charger_present) |=> ($stable(est_r) && prev_chg_r))
    else $error("estimate changed during charging");

  // Non-charging results carry the tracked estimate and a band level
  a_out_band: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.charging) |->
      (out_r.percent == est_r && out_r.level != LEVEL_CHARGING && out_r.level != 3'd0))
    else $error("result does not match estimate");

endmodule
